### rtl/mi_pkg.sv
// shared types and constants for the modular inverse core
`timescale 1ns / 1ps
package mi_pkg;

  localparam int FieldW = 31;
  localparam int CoefW  = 34;
  localparam int ShiftW = 5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_NOINV = 2'd2;

  typedef struct packed {
    logic sub_ok;
    logic align_ok;
  } step_t;

endpackage

### rtl/mi_alu.sv
// shared compare and subtract unit for one shift-subtract division step
`timescale 1ns / 1ps
module mi_alu import mi_pkg::*; (
  input  logic        [FieldW-1:0] rem,
  input  logic          [FieldW:0] dvs,
  input  logic signed  [CoefW-1:0] coef,
  input  logic signed  [CoefW-1:0] cshift,
  output step_t                    flags,
  output logic        [FieldW-1:0] rem_diff,
  output logic signed  [CoefW-1:0] coef_diff
);

  logic [FieldW+1:0] dvs_dbl;

  assign dvs_dbl        = {dvs, 1'b0};
  // can the divisor take one more doubling without passing the remainder
  assign flags.align_ok = dvs_dbl <= {2'b00, rem};
  assign flags.sub_ok   = dvs <= {1'b0, rem};
  assign rem_diff       = rem - dvs[FieldW-1:0];
  assign coef_diff      = coef - cshift;

endmodule

### rtl/modular_inverse_core.sv
// top level: extended euclid modular inverse with sequencer and output register
//
// channel  dir  handshake              payload
// s_*      in   s_tvalid / s_tready    s_tdata[30:0] value
// m_*      out  m_tvalid / m_tready    m_tdata[30:0] inverse_value, [32:31] status
// cfg_*    in   cfg_we                 cfg_wdata modulus
//
// out-of-range values go straight from the input beat to the final state, which registers their result.
// each euclid division step first aligns the divisor by doubling and then subtracts down,
// as one compare/subtract unit serves both phases; per item the sequencer checks, aligns,
// subtracts and finally registers the result.
// s_tready is high only while no item is in work; a held result stalls the final step.
// rst is synchronous and clears the sequencer, output valid and the modulus (to 2).
`timescale 1ns / 1ps
module modular_inverse_core import mi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [30:0] value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [30:0] inverse_value, [32:31] status
  input  logic        cfg_we,
  input  logic [30:0] cfg_wdata
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_ALIGN = 3'd2;
  localparam logic [2:0] S_SUB   = 3'd3;
  localparam logic [2:0] S_FINAL = 3'd4;

  logic        [2:0]        state;
  logic        [FieldW-1:0] modulus;
  logic        [FieldW-1:0] rem;
  logic        [FieldW-1:0] nrem;
  logic signed [CoefW-1:0]  coef;
  logic signed [CoefW-1:0]  ncoef;
  logic        [FieldW:0]   dvs;
  logic signed [CoefW-1:0]  cshift;
  logic        [ShiftW-1:0] k;
  logic                     range_err;
  logic        [FieldW-1:0] out_inv;
  logic        [1:0]        out_status;

  step_t                    flags;
  logic        [FieldW-1:0] rem_diff;
  logic signed [CoefW-1:0]  coef_diff;
  logic        [FieldW-1:0] rem_a;
  logic signed [CoefW-1:0]  coef_a;
  logic        [FieldW-1:0] value;
  logic signed [CoefW-1:0]  coef_wrap;
  logic                     out_free;

  mi_alu u_alu (
    .rem       (rem),
    .dvs       (dvs),
    .coef      (coef),
    .cshift    (cshift),
    .flags     (flags),
    .rem_diff  (rem_diff),
    .coef_diff (coef_diff)
  );

  assign value     = s_tdata[FieldW-1:0];
  assign s_tready  = state == S_IDLE;
  assign out_free  = !m_tvalid || m_tready;
  assign rem_a     = flags.sub_ok ? rem_diff : rem;
  assign coef_a    = flags.sub_ok ? coef_diff : coef;
  assign coef_wrap = coef + $signed({{(CoefW-FieldW){1'b0}}, modulus});
  assign m_tdata   = {7'd0, out_status, out_inv};

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= FieldW'(2);
    end else if (cfg_we) begin
      modulus <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (state == S_FINAL && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            range_err <= (value == '0) || (value >= modulus);
            rem       <= modulus;
            nrem      <= value;
            coef      <= '0;
            ncoef     <= CoefW'(1);
            state     <= ((value == '0) || (value >= modulus)) ? S_FINAL : S_CHECK;
          end
        end
        S_CHECK: begin
          if (nrem == '0) begin
            state <= S_FINAL;
          end else begin
            dvs    <= {1'b0, nrem};
            cshift <= ncoef;
            k      <= '0;
            state  <= S_ALIGN;
          end
        end
        S_ALIGN: begin
          if (flags.align_ok) begin
            dvs    <= {dvs[FieldW-1:0], 1'b0};
            cshift <= cshift <<< 1;
            k      <= k + 1'b1;
          end else begin
            state <= S_SUB;
          end
        end
        S_SUB: begin
          if (k == '0) begin
            // quotient complete: move the remainder pair and coefficient pair on
            rem   <= nrem;
            nrem  <= rem_a;
            coef  <= ncoef;
            ncoef <= coef_a;
            state <= S_CHECK;
          end else begin
            rem    <= rem_a;
            coef   <= coef_a;
            dvs    <= dvs >> 1;
            cshift <= cshift >>> 1;
            k      <= k - 1'b1;
          end
        end
        S_FINAL: begin
          if (out_free) begin
            if (range_err) begin
              out_inv    <= '0;
              out_status <= ST_RANGE;
            end else if (rem != FieldW'(1)) begin
              out_inv    <= '0;
              out_status <= ST_NOINV;
            end else begin
              out_inv    <= coef[CoefW-1] ? coef_wrap[FieldW-1:0] : coef[FieldW-1:0];
              out_status <= ST_OK;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_ok_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[32:31] == ST_OK |-> m_tdata[30:0] != '0)
    else $error("ok result with zero inverse");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[32:31] != ST_OK |-> m_tdata[30:0] == '0)
    else $error("error result with nonzero inverse");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[32:31] == ST_OK || m_tdata[32:31] == ST_RANGE ||
                  m_tdata[32:31] == ST_NOINV))
    else $error("unknown status code");

  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("ready again straight after an input beat");

  a_align_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_ALIGN |-> dvs <= {1'b0, rem})
    else $error("aligned divisor passed the remainder");

endmodule

### dv/modular_inverse_core_tb.sv
// testbench for the modular inverse core: random and edge-case requests checked against a predictor
`timescale 1ns / 1ps

class inverse_checker;
  typedef struct {
    bit [30:0] inv;
    bit [1:0]  st;
  } inverse_t;

  bit [30:0] modulus;
  inverse_t  inverses_due[$];
  int        errors;

  function new();
    modulus = 31'd2;
    errors  = 0;
  endfunction

  function void set_modulus(bit [30:0] m);
    modulus = m;
  endfunction

  // extended euclid on (modulus, value) in 64 bits, no overflow possible
  function inverse_t bezout_inverse(bit [30:0] a);
    longint r0, r1, t0, t1, q, tmp;
    inverse_t res;
    r0 = longint'(modulus);
    r1 = longint'(a);
    t0 = 0;
    t1 = 1;
    if (a == 0 || a >= modulus) begin
      res.inv = '0;
      res.st  = mi_pkg::ST_RANGE;
      return res;
    end
    while (r1 != 0) begin
      q   = r0 / r1;
      tmp = t0 - q * t1;
      t0  = t1;
      t1  = tmp;
      tmp = r0 - q * r1;
      r0  = r1;
      r1  = tmp;
    end
    if (r0 != 1) begin
      res.inv = '0;
      res.st  = mi_pkg::ST_NOINV;
    end else begin
      if (t0 < 0) t0 += longint'(modulus);
      res.inv = t0[30:0];
      res.st  = mi_pkg::ST_OK;
    end
    return res;
  endfunction

  function void note_request(bit [30:0] v);
    inverses_due.push_back(bezout_inverse(v));
  endfunction

  function void check_result(logic [39:0] tdata);
    inverse_t want;
    if (inverses_due.size() == 0) begin
      $display("%0t: unexpected result beat, expected none, actual inv=%0d status=%0d",
               $time, tdata[30:0], tdata[32:31]);
      errors++;
      return;
    end
    want = inverses_due.pop_front();
    if (tdata[30:0] !== want.inv || tdata[32:31] !== want.st) begin
      $display({"%0t: mismatch (modulus %0d), expected inv=%0d status=%0d,",
                " actual inv=%0d status=%0d"},
               $time, modulus, want.inv, want.st, tdata[30:0], tdata[32:31]);
      errors++;
    end
  endfunction

  function int pending();
    return inverses_due.size();
  endfunction
endclass

module modular_inverse_core_tb;
  import mi_pkg::*;

  localparam int unsigned FieldMax = 32'h7FFF_FFFF;
  localparam int unsigned Fib45    = 32'd1134903170;
  localparam int unsigned Fib46    = 32'd1836311903;
  localparam longint      CycleCap = 4_000_000;

  logic        clk;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [39:0] m_tdata;
  logic        cfg_we    = 1'b0;
  logic [30:0] cfg_wdata = '0;

  inverse_checker chk = new();
  longint cycles = 0;

  int rx_mode  = 0;
  int rx_left  = 0;
  int rx_block = 0;

  modular_inverse_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleCap) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) chk.check_result(m_tdata);
  end

  // receiver stall pattern, switching to a randomly chosen style whenever rx_left runs out
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(200, 2000);
    end else begin
      rx_left--;
    end
    rx_block++;
    case (rx_mode)
      0: m_tready = 1'b1;
      1: m_tready = $urandom_range(0, 1);
      2: m_tready = ($urandom_range(0, 7) == 0);
      default: m_tready = rx_block[4];
    endcase
  end

  function automatic int unsigned smallest_factor(int unsigned m);
    int unsigned p;
    if (m < 2) return m;
    for (p = 2; p * p <= m; p++) begin
      if (m % p == 0) return p;
    end
    return m;
  endfunction

  function automatic bit [30:0] pick_value(int unsigned m, int unsigned spf);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (m < 2) begin
      if (sel < 20) return '0;
      if (sel < 40) return 31'd1;
      return 31'($urandom());
    end
    if (sel < 45) return 31'($urandom_range(1, m - 1));
    if (sel < 62 && spf < m) return 31'(spf * $urandom_range(1, (m - 1) / spf));
    if (sel < 72) return 31'($urandom_range(m, FieldMax));
    if (sel < 76) return '0;
    if (sel < 80) return ($urandom_range(0, 1) != 0) ? 31'd1 : 31'(m - 1);
    return 31'($urandom());
  endfunction

  task automatic drive_value(input bit [30:0] v);
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata  = {1'b0, v};
    do @(posedge clk); while (!s_tready);
    chk.note_request(v);
  endtask

  task automatic drop_valid(input int gap);
    @(negedge clk);
    s_tvalid = 1'b0;
    s_tdata  = {1'b0, 31'($urandom())};
    repeat (gap) @(negedge clk);
  endtask

  // sender stops and waits for every result before the modulus may change
  task automatic drain();
    drop_valid(0);
    while (chk.pending() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int unsigned m, input bit write_mod, input bit directed,
                           input int n_rand);
    int unsigned spf;
    int burst;
    int gap;
    int i;
    bit [30:0] edge_vals[6];
    drain();
    repeat (8) @(posedge clk);
    if (write_mod) begin
      @(negedge clk);
      cfg_we    = 1'b1;
      cfg_wdata = m[30:0];
      @(negedge clk);
      cfg_we    = 1'b0;
      chk.set_modulus(m[30:0]);
    end
    spf = smallest_factor(m);
    if (directed) begin
      edge_vals = '{31'd0, 31'd1, 31'(m - 1), 31'(m), 31'(FieldMax), 31'(Fib45)};
      foreach (edge_vals[k]) drive_value(edge_vals[k]);
    end
    burst = 0;
    for (i = 0; i < n_rand; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        case ($urandom_range(0, 9))
          0, 1, 2: gap = 0;
          3, 4:    gap = $urandom_range(150, 300);
          default: gap = $urandom_range(1, 12);
        endcase
        if (gap != 0) drop_valid(gap);
      end
      burst--;
      drive_value(pick_value(m, spf));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    run_phase(32'd2, 1'b0, 1'b0, 25);           // reset modulus
    run_phase(FieldMax, 1'b1, 1'b1, 130);
    run_phase(FieldMax - 1, 1'b1, 1'b1, 130);
    run_phase(32'd0, 1'b1, 1'b1, 25);
    run_phase(32'd1, 1'b1, 1'b0, 25);
    run_phase(Fib46, 1'b1, 1'b1, 130);          // longest euclid chain
    run_phase(32'd223092870, 1'b1, 1'b0, 130);  // product of the first primes
    run_phase(32'h4000_0000, 1'b1, 1'b0, 130);
    run_phase(32'd3, 1'b1, 1'b0, 130);
    run_phase(32'd97, 1'b1, 1'b0, 130);
    run_phase($urandom_range(2, FieldMax), 1'b1, 1'b0, 130);
    run_phase($urandom_range(2, 1000), 1'b1, 1'b0, 130);
    run_phase($urandom_range(2, 65535), 1'b1, 1'b0, 130);
    run_phase($urandom_range(2, FieldMax), 1'b1, 1'b0, 130);

    drain();
    repeat (300) @(posedge clk);
    if (chk.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
